// ----- src/qfe_pkg.sv -----
// Package for the Euler-angle to quaternion converter: widths, CORDIC table
// and fixed-point helpers. No dependencies.
`timescale 1ns / 1ps
package qfe_pkg;
  localparam int ANGLE_BITS    = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int QW            = 16;
  localparam int CW            = 34;
  localparam int ZW            = 36;
  localparam int MW            = 2 * CW;

  localparam logic signed [CW-1:0] INV_GAIN = CW'(64'sd652032875);

  typedef logic signed [CW-1:0] cval_t;
  typedef logic signed [ZW-1:0] zval_t;

  function automatic zval_t atan_val(input int i);
    logic [31:0] t;
    begin
      t = 32'd0;
      case (i)
        0: t = 32'd536870912;   1: t = 32'd316933406;
        2: t = 32'd167458907;   3: t = 32'd85004756;
        4: t = 32'd42667331;    5: t = 32'd21354465;
        6: t = 32'd10679838;    7: t = 32'd5340245;
        8: t = 32'd2670163;     9: t = 32'd1335087;
        10: t = 32'd667544;     11: t = 32'd333772;
        12: t = 32'd166886;     13: t = 32'd83443;
        14: t = 32'd41722;      15: t = 32'd20861;
        16: t = 32'd10430;      17: t = 32'd5215;
        18: t = 32'd2608;       19: t = 32'd1304;
        20: t = 32'd652;        21: t = 32'd326;
        22: t = 32'd163;        23: t = 32'd81;
        24: t = 32'd41;         25: t = 32'd20;
        26: t = 32'd10;         27: t = 32'd5;
        28: t = 32'd3;          29: t = 32'd1;
        30: t = 32'd1;
        default: t = 32'd0;
      endcase
      atan_val = zval_t'({t, 2'b00});
    end
  endfunction

  // Q4.30 product rounded back to Q4.30.
  function automatic cval_t mul_q30(input cval_t a, input cval_t b);
    logic signed [MW-1:0] p;
    begin
      p = a * b + (MW'(1) <<< 29);
      mul_q30 = cval_t'(p >>> 30);
    end
  endfunction

  function automatic logic signed [QW-1:0] to_q15(input cval_t v);
    logic signed [CW:0] r;
    begin
      r = (signed'({v[CW-1], v}) + (CW+1)'(1 << 14)) >>> 15;
      if (r > 32767) to_q15 = 16'sh7fff;
      else if (r < -32768) to_q15 = 16'sh8000;
      else to_q15 = r[QW-1:0];
    end
  endfunction
endpackage

// ----- src/qfe_cordic.sv -----
// Pipelined CORDIC rotator giving sine and cosine of half a binary angle.
// One register stage per iteration. Depends on qfe_pkg.
`timescale 1ns / 1ps
module qfe_cordic (
  input  logic                                  clk,
  input  logic signed [qfe_pkg::ANGLE_BITS-1:0] angle,
  output qfe_pkg::cval_t                        sin_val,
  output qfe_pkg::cval_t                        cos_val
);
  import qfe_pkg::*;

  cval_t x [CORDIC_STAGES+1];
  cval_t y [CORDIC_STAGES+1];
  zval_t z [CORDIC_STAGES+1];

  // Half angle: 2^34 units per circle.
  always_comb begin
    x[0] = INV_GAIN;
    y[0] = '0;
    z[0] = zval_t'(angle) <<< (33 - ANGLE_BITS);
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (!z[i][ZW-1]) begin
        x[i+1] <= x[i] - (y[i] >>> i);
        y[i+1] <= y[i] + (x[i] >>> i);
        z[i+1] <= z[i] - atan_val(i);
      end else begin
        x[i+1] <= x[i] + (y[i] >>> i);
        y[i+1] <= y[i] - (x[i] >>> i);
        z[i+1] <= z[i] + atan_val(i);
      end
    end
  end

  assign sin_val = y[CORDIC_STAGES];
  assign cos_val = x[CORDIC_STAGES];
endmodule

// ----- src/qfe_combine.sv -----
// Three-stage product network forming x, y, z, w from the half-angle
// sines and cosines. Depends on qfe_pkg.
`timescale 1ns / 1ps
module qfe_combine (
  input  logic                          clk,
  input  qfe_pkg::cval_t                sz, cz, sy, cy, sx, cx,
  output logic signed [qfe_pkg::QW-1:0] qx, qy, qz, qw
);
  import qfe_pkg::*;

  cval_t sxcy, cxcy, sxsy, cxsy, sz1, cz1;
  cval_t p0, p1, p2, p3, p4, p5, p6, p7;

  always_ff @(posedge clk) begin
    sxcy <= mul_q30(sx, cy);
    cxcy <= mul_q30(cx, cy);
    sxsy <= mul_q30(sx, sy);
    cxsy <= mul_q30(cx, sy);
    sz1  <= sz;
    cz1  <= cz;
    p0 <= mul_q30(cxsy, sz1);
    p1 <= mul_q30(sxcy, cz1);
    p2 <= mul_q30(cxsy, cz1);
    p3 <= mul_q30(sxcy, sz1);
    p4 <= mul_q30(sxsy, cz1);
    p5 <= mul_q30(cxcy, sz1);
    p6 <= mul_q30(cxcy, cz1);
    p7 <= mul_q30(sxsy, sz1);
    qx <= to_q15(p0 - p1);
    qy <= to_q15(-p2 - p3);
    qz <= to_q15(p4 - p5);
    qw <= to_q15(p6 + p7);
  end
endmodule

// ----- src/quaternion_from_euler_angles.sv -----
// Top level: Euler angles to quaternion converter.
// Depends on qfe_pkg, qfe_cordic and qfe_combine.
//
//  Channel  | Handshake     | Payload
//  ---------+---------------+-----------------------------------------
//  input    | start / busy  | yaw_angle, pitch_angle, roll_angle
//  result   | done strobe   | quat_x, quat_y, quat_z, quat_w
//
// One item may enter every cycle; busy is always low. A result passes
// through the CORDIC iteration pipeline and then the three product
// stages. Reset clears the valid bits only. The receiver takes each
// result in the cycle it shows.
`timescale 1ns / 1ps
module quaternion_from_euler_angles (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [qfe_pkg::ANGLE_BITS-1:0] yaw_angle,
  input  logic signed [qfe_pkg::ANGLE_BITS-1:0] pitch_angle,
  input  logic signed [qfe_pkg::ANGLE_BITS-1:0] roll_angle,
  output logic                                  done,
  output logic signed [qfe_pkg::QW-1:0]         quat_x,
  output logic signed [qfe_pkg::QW-1:0]         quat_y,
  output logic signed [qfe_pkg::QW-1:0]         quat_z,
  output logic signed [qfe_pkg::QW-1:0]         quat_w
);
  import qfe_pkg::*;

  localparam int LAT = CORDIC_STAGES + 3;

  cval_t sz, cz, sy, cy, sx, cx;
  logic [LAT-1:0] vld;

  assign busy = 1'b0;

  qfe_cordic u_yaw   (.clk(clk), .angle(yaw_angle),   .sin_val(sz), .cos_val(cz));
  qfe_cordic u_pitch (.clk(clk), .angle(pitch_angle), .sin_val(sy), .cos_val(cy));
  qfe_cordic u_roll  (.clk(clk), .angle(roll_angle),  .sin_val(sx), .cos_val(cx));

  qfe_combine u_comb (
    .clk(clk), .sz(sz), .cz(cz), .sy(sy), .cy(cy), .sx(sx), .cx(cx),
    .qx(quat_x), .qy(quat_y), .qz(quat_z), .qw(quat_w)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start};
    end
  end

  assign done = vld[LAT-1];
endmodule
